// File: src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define PSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, reset masks the check
`define PSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// File: src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the process slot scheduler.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam logic [2:0] MODE_YIELD = 3'd0;
    localparam logic [2:0] MODE_SLEEP = 3'd1;
    localparam logic [2:0] MODE_WAKE  = 3'd2;
    localparam logic [2:0] MODE_EXIT  = 3'd3;
    localparam logic [2:0] MODE_REAP  = 3'd4;
    localparam logic [2:0] MODE_SPAWN = 3'd5;

    // channel that exit wakes and a failed reap sleeps on
    localparam logic [15:0] CH_EXIT = 16'hFFFD;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] channel_value;
        logic [15:0]        target_pid;
    } t_req;

    typedef struct packed {
        logic [3:0]  running_slot;
        logic [15:0] running_pid;
        logic        switched;
        logic [15:0] new_pid;
        logic [4:0]  woken_count;
        logic        reaped;
        logic        status;
    } t_rsp;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SPAWN,
        OP_PUSH_RUN,
        OP_SLEEP_RUN,
        OP_KILL_RUN,
        OP_POP,
        OP_WAKE,
        OP_REAP_SCAN,
        OP_REAP_DEL
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [15:0] ch;
    } t_cell_cmd;

    // flags passed from cell to cell along the row
    typedef struct packed {
        logic found;
        logic hit;
    } t_link;

endpackage

// File: src/psc_cell.sv
// ----------------------------------------------------------------------------
// psc_cell
// One process slot: status, pid, channel and its rank in the list it is on.
// ----------------------------------------------------------------------------
module psc_cell #(
    parameter int IDX_W    = 4,
    parameter int PID_BITS = 16,
    parameter int SLOT_ID  = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  psc_pkg::t_cell_cmd      i_cmd,
    input  logic [IDX_W-1:0]        i_key,
    input  logic [IDX_W-1:0]        i_tail,
    input  logic [IDX_W-1:0]        i_shift,
    input  logic [PID_BITS-1:0]     i_pid,
    input  psc_pkg::t_link          i_link,
    input  logic [IDX_W-1:0]        i_slot,
    input  logic [PID_BITS-1:0]     i_hit_pid,
    output psc_pkg::t_link          o_link,
    output logic [IDX_W-1:0]        o_slot,
    output logic [PID_BITS-1:0]     o_hit_pid
);

    typedef enum logic [2:0] {
        ST_UNUSED,
        ST_READY,
        ST_RUNNING,
        ST_SLEEP,
        ST_KILLED
    } t_slot_st;

    t_slot_st            r_st, n_st;
    logic [IDX_W-1:0]    r_rank, n_rank;
    logic [PID_BITS-1:0] r_pid, n_pid;
    logic [15:0]         r_ch, n_ch;
    logic                w_self_hit;
    logic                w_take;

    always_comb begin
        case (i_cmd.op)
            psc_pkg::OP_POP:       w_self_hit = (r_st == ST_READY) && (r_rank == '0);
            psc_pkg::OP_WAKE:      w_self_hit = (r_st == ST_SLEEP) && (r_rank == i_key)
                                                && (r_ch == i_cmd.ch);
            psc_pkg::OP_REAP_SCAN: w_self_hit = (r_st == ST_KILLED) && (r_rank == i_key)
                                                && (r_pid == i_pid);
            default:               w_self_hit = 1'b0;
        endcase
    end

    // lowest unused slot wins a spawn
    assign w_take = (i_cmd.op == psc_pkg::OP_SPAWN) && (r_st == ST_UNUSED) && !i_link.found;

    always_comb begin
        n_st   = r_st;
        n_rank = r_rank;
        n_pid  = r_pid;
        n_ch   = r_ch;
        case (i_cmd.op)
            psc_pkg::OP_SPAWN: begin
                if (w_take) begin
                    n_st   = ST_READY;
                    n_rank = i_tail;
                    n_pid  = i_pid;
                end
            end
            psc_pkg::OP_PUSH_RUN: begin
                if (r_st == ST_RUNNING) begin
                    n_st   = ST_READY;
                    n_rank = i_tail;
                end
            end
            psc_pkg::OP_SLEEP_RUN: begin
                if (r_st == ST_RUNNING) begin
                    n_st   = ST_SLEEP;
                    n_rank = i_tail;
                    n_ch   = i_cmd.ch;
                end
            end
            psc_pkg::OP_KILL_RUN: begin
                if (r_st == ST_RUNNING) begin
                    n_st   = ST_KILLED;
                    n_rank = i_tail;
                end
            end
            psc_pkg::OP_POP: begin
                if (r_st == ST_READY) begin
                    if (r_rank == '0) begin
                        n_st = ST_RUNNING;
                    end else begin
                        n_rank = r_rank - IDX_W'(1);
                    end
                end
            end
            psc_pkg::OP_WAKE: begin
                // sleepers that stay close the gaps left by those woken earlier
                if ((r_st == ST_SLEEP) && (r_rank == i_key)) begin
                    if (w_self_hit) begin
                        n_st   = ST_READY;
                        n_rank = i_tail;
                    end else begin
                        n_rank = r_rank - i_shift;
                    end
                end
            end
            psc_pkg::OP_REAP_DEL: begin
                if (r_st == ST_KILLED) begin
                    if (r_rank == i_key) begin
                        n_st  = ST_UNUSED;
                        n_pid = '0;
                        n_ch  = '0;
                    end else if (r_rank > i_key) begin
                        n_rank = r_rank - IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_UNUSED;
            r_rank <= '0;
            r_pid  <= '0;
            r_ch   <= '0;
        end else begin
            r_st   <= n_st;
            r_rank <= n_rank;
            r_pid  <= n_pid;
            r_ch   <= n_ch;
        end
    end

    assign o_link.found = i_link.found || (r_st == ST_UNUSED);
    assign o_link.hit   = i_link.hit || w_self_hit;
    assign o_slot       = i_link.hit ? i_slot : IDX_W'(SLOT_ID);
    assign o_hit_pid    = i_link.hit ? i_hit_pid : r_pid;

endmodule

// File: src/process_slot_scheduler.sv
// ----------------------------------------------------------------------------
// process_slot_scheduler
// Round-robin task manager over a row of process slot cells.
// ----------------------------------------------------------------------------
// A command is taken at a rising edge with i_start high and o_busy low. Its
// result appears on o_rsp, marked by o_done for exactly one cycle, and cannot
// be held off. Spawn, yield and the ignored modes need no sweep; wake, exit
// and reap sweep the sleep or kill list one rank per cycle across the cell row,
// so their length grows with the number of sleepers or killed tasks.
module process_slot_scheduler #(
    parameter int SLOTS    = 16,
    parameter int PID_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  psc_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_done,
    output psc_pkg::t_rsp o_rsp
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPAWN,
        S_PUSH,
        S_BLOCK,
        S_KILL,
        S_WAKE,
        S_POP,
        S_SCAN,
        S_DEL,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [2:0]          r_mode;
    logic [15:0]         r_ch;
    logic [15:0]         r_tpid;
    logic [CNT_W-1:0]    r_rdy, r_slp, r_kill, r_woken;
    logic [IDX_W-1:0]    r_scan;
    logic [IDX_W-1:0]    r_run;
    logic [PID_BITS-1:0] r_run_pid;
    logic [PID_BITS-1:0] r_next;
    logic [PID_BITS-1:0] r_newpid;
    logic                r_sw, r_reaped, r_status;
    logic                r_done;
    psc_pkg::t_rsp       r_rsp;

    psc_pkg::t_cell_cmd  w_cmd;
    logic [IDX_W-1:0]    w_tail, w_shift;
    logic [PID_BITS-1:0] w_pid;
    psc_pkg::t_link      lk      [SLOTS];
    logic [IDX_W-1:0]    lk_slot [SLOTS];
    logic [PID_BITS-1:0] lk_pid  [SLOTS];
    logic                w_hit, w_found;
    logic                w_wake_last, w_scan_last;

    // slot 0 is the idle task and has no cell
    assign lk[0]      = '0;
    assign lk_slot[0] = '0;
    assign lk_pid[0]  = '0;

    for (genvar g = 1; g < SLOTS; g++) begin : g_cell
        psc_cell #(
            .IDX_W    (IDX_W),
            .PID_BITS (PID_BITS),
            .SLOT_ID  (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_key     (r_scan),
            .i_tail    (w_tail),
            .i_shift   (w_shift),
            .i_pid     (w_pid),
            .i_link    (lk[g-1]),
            .i_slot    (lk_slot[g-1]),
            .i_hit_pid (lk_pid[g-1]),
            .o_link    (lk[g]),
            .o_slot    (lk_slot[g]),
            .o_hit_pid (lk_pid[g])
        );
    end

    assign w_hit   = lk[SLOTS-1].hit;
    assign w_found = lk[SLOTS-1].found;

    always_comb begin
        w_cmd.op = psc_pkg::OP_NONE;
        w_cmd.ch = r_ch;
        w_tail   = '0;
        w_shift  = '0;
        w_pid    = r_next;
        case (r_state)
            S_SPAWN: begin
                w_cmd.op = psc_pkg::OP_SPAWN;
                w_tail   = IDX_W'(r_rdy);
            end
            S_PUSH: begin
                w_cmd.op = psc_pkg::OP_PUSH_RUN;
                w_tail   = IDX_W'(r_rdy);
            end
            S_BLOCK: begin
                w_cmd.op = psc_pkg::OP_SLEEP_RUN;
                w_tail   = IDX_W'(r_slp);
            end
            S_KILL: begin
                w_cmd.op = psc_pkg::OP_KILL_RUN;
                w_tail   = IDX_W'(r_kill);
            end
            S_WAKE: begin
                w_cmd.op = psc_pkg::OP_WAKE;
                w_tail   = IDX_W'(r_rdy);
                w_shift  = IDX_W'(r_woken);
            end
            S_POP:  w_cmd.op = psc_pkg::OP_POP;
            S_SCAN: begin
                w_cmd.op = psc_pkg::OP_REAP_SCAN;
                w_pid    = PID_BITS'(r_tpid);
            end
            S_DEL:  w_cmd.op = psc_pkg::OP_REAP_DEL;
            default: begin
            end
        endcase
    end

    assign w_wake_last = (CNT_W'(r_scan) == (r_slp - CNT_W'(1)));
    assign w_scan_last = (CNT_W'(r_scan) == (r_kill - CNT_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rdy     <= '0;
            r_slp     <= '0;
            r_kill    <= '0;
            r_woken   <= '0;
            r_scan    <= '0;
            r_run     <= '0;
            r_run_pid <= '0;
            r_next    <= PID_BITS'(1);
            r_done    <= 1'b0;
        end else begin
            r_done <= (r_state == S_DONE);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mode   <= i_req.mode;
                        r_tpid   <= i_req.target_pid;
                        r_woken  <= '0;
                        r_reaped <= 1'b0;
                        r_status <= 1'b0;
                        r_newpid <= '0;
                        r_scan   <= '0;
                        case (i_req.mode)
                            psc_pkg::MODE_YIELD: begin
                                r_ch <= i_req.channel_value;
                                if (r_rdy != '0) begin
                                    r_sw    <= 1'b1;
                                    r_state <= (r_run != '0) ? S_PUSH : S_POP;
                                end else begin
                                    r_sw    <= 1'b0;
                                    r_state <= S_DONE;
                                end
                            end
                            psc_pkg::MODE_SLEEP: begin
                                r_ch    <= i_req.channel_value;
                                r_sw    <= 1'b1;
                                r_state <= (r_run != '0) ? S_BLOCK : S_POP;
                            end
                            psc_pkg::MODE_WAKE: begin
                                r_ch    <= i_req.channel_value;
                                r_sw    <= 1'b0;
                                r_state <= (r_slp != '0) ? S_WAKE : S_DONE;
                            end
                            psc_pkg::MODE_EXIT: begin
                                r_sw <= 1'b1;
                                r_ch <= psc_pkg::CH_EXIT;
                                if (r_run != '0) begin
                                    r_state <= S_KILL;
                                end else begin
                                    r_state <= (r_slp != '0) ? S_WAKE : S_POP;
                                end
                            end
                            psc_pkg::MODE_REAP: begin
                                if (r_kill != '0) begin
                                    r_ch    <= i_req.channel_value;
                                    r_sw    <= 1'b0;
                                    r_state <= S_SCAN;
                                end else begin
                                    r_sw    <= 1'b1;
                                    r_ch    <= psc_pkg::CH_EXIT;
                                    r_state <= (r_run != '0) ? S_BLOCK : S_POP;
                                end
                            end
                            psc_pkg::MODE_SPAWN: begin
                                r_ch    <= i_req.channel_value;
                                r_sw    <= 1'b0;
                                r_state <= S_SPAWN;
                            end
                            default: begin
                                r_ch    <= i_req.channel_value;
                                r_sw    <= 1'b0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SPAWN: begin
                    if (w_found) begin
                        r_newpid <= r_next;
                        r_next   <= r_next + PID_BITS'(1);
                        r_rdy    <= r_rdy + CNT_W'(1);
                    end else begin
                        r_status <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_PUSH: begin
                    r_rdy   <= r_rdy + CNT_W'(1);
                    r_state <= S_POP;
                end
                S_BLOCK: begin
                    r_slp   <= r_slp + CNT_W'(1);
                    r_state <= S_POP;
                end
                S_KILL: begin
                    r_kill  <= r_kill + CNT_W'(1);
                    r_scan  <= '0;
                    r_state <= (r_slp != '0) ? S_WAKE : S_POP;
                end
                S_WAKE: begin
                    if (w_hit) begin
                        r_rdy   <= r_rdy + CNT_W'(1);
                        r_woken <= r_woken + CNT_W'(1);
                    end
                    if (w_wake_last) begin
                        r_slp   <= r_slp - r_woken - CNT_W'(w_hit);
                        r_state <= (r_mode == psc_pkg::MODE_EXIT) ? S_POP : S_DONE;
                    end else begin
                        r_scan <= r_scan + IDX_W'(1);
                    end
                end
                S_POP: begin
                    if (r_rdy != '0) begin
                        r_run     <= lk_slot[SLOTS-1];
                        r_run_pid <= lk_pid[SLOTS-1];
                        r_rdy     <= r_rdy - CNT_W'(1);
                    end else begin
                        r_run     <= '0;
                        r_run_pid <= '0;
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_state <= S_DEL;
                    end else if (w_scan_last) begin
                        // no killed task with that pid: caller waits on the exit channel
                        r_sw    <= 1'b1;
                        r_ch    <= psc_pkg::CH_EXIT;
                        r_state <= (r_run != '0) ? S_BLOCK : S_POP;
                    end else begin
                        r_scan <= r_scan + IDX_W'(1);
                    end
                end
                S_DEL: begin
                    r_kill   <= r_kill - CNT_W'(1);
                    r_reaped <= 1'b1;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    r_rsp.running_slot <= 4'(r_run);
                    r_rsp.running_pid  <= 16'(r_run_pid);
                    r_rsp.switched     <= r_sw;
                    r_rsp.new_pid      <= 16'(r_newpid);
                    r_rsp.woken_count  <= (r_woken > CNT_W'(31)) ? 5'd31 : 5'(r_woken);
                    r_rsp.reaped       <= r_reaped;
                    r_rsp.status       <= r_status;
                    r_state            <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// File: src/psc_checker.sv
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks of the process slot scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          o_busy,
    input logic          o_done,
    input psc_pkg::t_rsp o_rsp
);

    `PSC_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `PSC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // a successful reap never hands the cpu away
    `PSC_ASSERT_NOW(a_reap_no_switch, i_clk, i_rst_n, o_done && o_rsp.reaped, !o_rsp.switched)
    // full table: no pid and nothing woken
    `PSC_ASSERT_NOW(a_full_no_pid, i_clk, i_rst_n, o_done && o_rsp.status,
        (o_rsp.new_pid == 16'd0) && (o_rsp.woken_count == 5'd0))

endmodule

bind process_slot_scheduler psc_checker u_psc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

// File: dv/tb_process_slot_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_process_slot_scheduler
// Self-checking bench for the process slot scheduler: a behavioral task table
// predicts each response; random command mixes with idle gaps on the sender.
// ----------------------------------------------------------------------------
module tb_process_slot_scheduler;

    localparam int NSLOT = 16;
    localparam int RUN_LIMIT = 400000;
    localparam logic [2:0] ST_UNUSED  = 3'd0;
    localparam logic [2:0] ST_READY   = 3'd2;
    localparam logic [2:0] ST_RUNNING = 3'd3;
    localparam logic [2:0] ST_SLEEP   = 3'd4;
    localparam logic [2:0] ST_KILLED  = 3'd5;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_start = 1'b0;
    psc_pkg::t_req  i_req = '0;
    logic           o_busy, o_done;
    psc_pkg::t_rsp  o_rsp;

    process_slot_scheduler i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_req(i_req),
        .o_busy(o_busy), .o_done(o_done), .o_rsp(o_rsp)
    );

    always #4 i_clk = ~i_clk;

    // predicted task table
    logic [2:0]  tbl_state [NSLOT];
    logic [15:0] tbl_pid   [NSLOT];
    logic [15:0] tbl_chan  [NSLOT];
    logic [3:0]  ready_q   [$];
    logic [3:0]  sleepers  [$];
    logic [3:0]  killed    [$];
    logic [3:0]  cur_slot;
    logic [15:0] pid_next;

    psc_pkg::t_req  req_q [$];
    psc_pkg::t_rsp  rsp_expected [$];
    int    errors = 0;
    int    n_rsp = 0;
    int    cycles = 0;
    int    gap = 0;
    bit    calm = 1'b0;
    bit    drain_hold = 1'b0;
    int    n_mode [8];

    function automatic void table_reset();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_state[i] = ST_UNUSED;
            tbl_pid[i] = '0;
            tbl_chan[i] = '0;
        end
        tbl_state[0] = ST_RUNNING;
        ready_q.delete(); sleepers.delete(); killed.delete();
        cur_slot = '0;
        pid_next = 16'd1;
    endfunction

    function automatic void make_ready(logic [3:0] s);
        if (ready_q.size() < NSLOT) begin
            ready_q.push_back(s);
            tbl_state[s] = ST_READY;
        end
    endfunction

    function automatic int wake_on(logic [15:0] ch);
        logic [3:0] kept [$];
        int n;
        n = 0;
        foreach (sleepers[i]) begin
            if (tbl_chan[sleepers[i]] == ch) begin
                make_ready(sleepers[i]);
                n++;
            end else kept.push_back(sleepers[i]);
        end
        sleepers = kept;
        return n;
    endfunction

    function automatic void pick_next();
        logic [3:0] nx;
        nx = '0;
        if (ready_q.size() > 0) nx = ready_q.pop_front();
        tbl_state[nx] = ST_RUNNING;
        cur_slot = nx;
    endfunction

    function automatic void block_on(logic [15:0] ch);
        if (cur_slot != 0 && sleepers.size() < NSLOT) begin
            tbl_state[cur_slot] = ST_SLEEP;
            tbl_chan[cur_slot] = ch;
            sleepers.push_back(cur_slot);
        end
        pick_next();
    endfunction

    function automatic psc_pkg::t_rsp schedule_cmd(psc_pkg::t_req r);
        psc_pkg::t_rsp o;
        int   woke, hit, free_slot;
        o = '0;
        woke = 0;
        case (r.mode)
            psc_pkg::MODE_YIELD: if (ready_q.size() > 0) begin
                tbl_state[cur_slot] = ST_READY;
                if (cur_slot != 0) make_ready(cur_slot);
                pick_next();
                o.switched = 1'b1;
            end
            psc_pkg::MODE_SLEEP: begin
                block_on(r.channel_value);
                o.switched = 1'b1;
            end
            psc_pkg::MODE_WAKE: woke = wake_on(r.channel_value);
            psc_pkg::MODE_EXIT: begin
                if (cur_slot != 0 && killed.size() < NSLOT) begin
                    tbl_state[cur_slot] = ST_KILLED;
                    killed.push_back(cur_slot);
                end
                woke = wake_on(psc_pkg::CH_EXIT);
                pick_next();
                o.switched = 1'b1;
            end
            psc_pkg::MODE_REAP: begin
                hit = -1;
                foreach (killed[i])
                    if (hit < 0 && tbl_pid[killed[i]] == r.target_pid) hit = i;
                if (hit >= 0) begin
                    free_slot = killed[hit];
                    killed.delete(hit);
                    tbl_state[free_slot] = ST_UNUSED;
                    tbl_pid[free_slot] = '0;
                    tbl_chan[free_slot] = '0;
                    o.reaped = 1'b1;
                end else begin
                    block_on(psc_pkg::CH_EXIT);
                    o.switched = 1'b1;
                end
            end
            psc_pkg::MODE_SPAWN: begin
                free_slot = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (free_slot < 0 && tbl_state[i] == ST_UNUSED) free_slot = i;
                if (free_slot >= 0) begin
                    o.new_pid = pid_next;
                    tbl_pid[free_slot] = pid_next;
                    pid_next = pid_next + 16'd1;
                    make_ready(free_slot[3:0]);
                end else o.status = 1'b1;
            end
            default: ;
        endcase
        o.running_slot = cur_slot;
        o.running_pid = tbl_pid[cur_slot];
        o.woken_count = (woke > 31) ? 5'd31 : woke[4:0];
        return o;
    endfunction

    // pid of some killed task, or a random one
    function automatic logic [15:0] reap_target();
        if (killed.size() > 0 && $urandom_range(0, 3) != 0)
            return tbl_pid[killed[$urandom_range(0, killed.size() - 1)]];
        return 16'($urandom);
    endfunction

    // driver: predicts on acceptance, loads the next request at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                rsp_expected.push_back(schedule_cmd(i_req));
                n_mode[i_req.mode]++;
            end
            if (!(i_start && o_busy)) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    i_start <= 1'b0;
                end else if (drain_hold && rsp_expected.size() > 0) begin
                    i_start <= 1'b0;
                end else if (req_q.size() > 0) begin
                    i_req <= req_q.pop_front();
                    i_start <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 14);
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        psc_pkg::t_rsp e;
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            n_rsp <= n_rsp + 1;
            if (rsp_expected.size() == 0) begin
                $display("%0t unexpected response %p", $realtime, o_rsp);
                errors <= errors + 1;
            end else begin
                e = rsp_expected.pop_front();
                if (o_rsp !== e) begin
                    $display("%0t mismatch expected %p actual %p", $realtime, e, o_rsp);
                    errors <= errors + 1;
                end
            end
        end
    end

    function automatic psc_pkg::t_req cmd(logic [2:0] m, logic [15:0] ch, logic [15:0] p);
        psc_pkg::t_req r;
        r.mode = m;
        r.channel_value = ch;
        r.target_pid = p;
        return r;
    endfunction

    initial begin
        int k, burst;
        logic [2:0] m;
        table_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle yields, idle blocking, spawn to full table, wraps
        req_q.push_back(cmd(psc_pkg::MODE_YIELD, 16'h0000, 16'h0000));
        req_q.push_back(cmd(psc_pkg::MODE_SLEEP, 16'h7FFF, 16'hFFFF));
        req_q.push_back(cmd(psc_pkg::MODE_EXIT,  16'h8000, 16'h0000));
        req_q.push_back(cmd(psc_pkg::MODE_REAP,  16'hFFFF, 16'hFFFF));
        req_q.push_back(cmd(3'd6, 16'hFFFF, 16'hFFFF));
        req_q.push_back(cmd(3'd7, 16'h0000, 16'h0000));
        for (int i = 0; i < 16; i++)
            req_q.push_back(cmd(psc_pkg::MODE_SPAWN, 16'h0, 16'h0));
        req_q.push_back(cmd(psc_pkg::MODE_YIELD, 16'h0, 16'h0));
        req_q.push_back(cmd(psc_pkg::MODE_SLEEP, psc_pkg::CH_EXIT, 16'h0));
        req_q.push_back(cmd(psc_pkg::MODE_EXIT,  16'h0, 16'h0));
        req_q.push_back(cmd(psc_pkg::MODE_REAP,  16'h0, 16'd1));
        wait (req_q.size() == 0 && !i_start);

        // sender waits for the table to settle before going on
        drain_hold = 1'b1;
        wait (rsp_expected.size() == 0);
        drain_hold = 1'b0;

        // random: mostly well-formed bursts on a few channels, some noise
        k = 0;
        while (k < 750) begin
            if (k > 650) calm = 1'b1;
            burst = $urandom_range(1, 8);
            for (int j = 0; j < burst; j++) begin
                m = 3'($urandom_range(0, 5));
                if ($urandom_range(0, 40) == 0) m = 3'($urandom_range(6, 7));
                if ($urandom_range(0, 3) == 0) m = psc_pkg::MODE_SPAWN;
                if ($urandom_range(0, 9) == 0)
                    req_q.push_back(cmd(m, 16'($urandom), 16'($urandom)));
                else
                    req_q.push_back(cmd(m, 16'($urandom_range(0, 3)) ^
                                    ($urandom_range(0, 3) == 0 ? psc_pkg::CH_EXIT : 16'h0),
                                    reap_target()));
                k++;
            end
            // reap targets track the table, so wait for this burst to land
            wait (req_q.size() == 0 && !i_start);
        end
        wait (rsp_expected.size() == 0);
        repeat (80) @(posedge i_clk);
        $display("ran %0d responses: yield %0d sleep %0d wake %0d exit %0d reap %0d spawn %0d",
                 n_rsp, n_mode[0], n_mode[1], n_mode[2], n_mode[3], n_mode[4], n_mode[5]);
        $display("ignored modes %0d, random idle gaps and one full drain pause",
                 n_mode[6] + n_mode[7]);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        wait (cycles >= RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end
endmodule
